### src/csma_backoff_tx_scheduler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bus access scheduler
// Simulation builds get concurrent assertions; synthesis gets empty bodies.
// ----------------------------------------------------------------------------
`ifndef CSMA_BACKOFF_TX_SCHEDULER_UNIT_MACROS_SVH
`define CSMA_BACKOFF_TX_SCHEDULER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CBTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cbts assertion failed");

// next-cycle implication
`define CBTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cbts assertion failed");

`else

`define CBTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CBTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/cbts_pkg.sv
// ----------------------------------------------------------------------------
// cbts_pkg
// Shared types and constants of the bus access scheduler.
// ----------------------------------------------------------------------------
package cbts_pkg;

	localparam int RESPONSE_MAX     = 24;
	localparam int BACKOFF_EXP_CAP  = 8;
	localparam int BACKOFF_EXP_BASE = 5;

	localparam logic [15:0] IFS_TICKS_RST   = 16'd100;
	localparam logic [12:0] TX_CAPACITY_RST = 13'd256;
	localparam logic [15:0] LFSR_SEED_RST   = 16'd44257;
	localparam logic [15:0] LFSR_TAPS       = 16'hB400;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_LOAD   = 3'd1,
		OP_CLEAR  = 3'd2,
		OP_START  = 3'd3,
		OP_PHY    = 3'd4,
		OP_READY  = 3'd5,
		OP_DIRECT = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BUSY     = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_RECEIVED  = 3'd1,
		EV_FAULT     = 3'd2,
		EV_RECOVERED = 3'd3,
		EV_TX_READY  = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		TX_IDLE     = 2'd0,
		TX_READY    = 2'd1,
		TX_SENDING  = 2'd2,
		TX_WAIT_ACK = 2'd3
	} tx_state_t;

	localparam logic [1:0] RR_FRAME = 2'd1;
	localparam logic [1:0] RR_FAULT = 2'd2;
	localparam logic [1:0] MR_OK    = 2'd0;
	localparam logic [1:0] MR_FAULT = 2'd1;

	localparam logic [1:0] CFG_IFS_TICKS   = 2'd0;
	localparam logic [1:0] CFG_TX_CAPACITY = 2'd1;
	localparam logic [1:0] CFG_LFSR_SEED   = 2'd2;

	typedef struct packed {
		logic [2:0]  operation;
		logic [12:0] frame_length;
		logic [15:0] retry_limit;
		logic [1:0]  recv_report;
		logic        send_finished;
		logic [1:0]  monitor_report;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  posted_event;
		logic        start_send;
		logic        send_from_cache;
		logic [12:0] send_length;
		logic        awaiting_ack;
		logic        bus_locked;
		logic        bus_faulted;
		logic [1:0]  tx_state;
	} result_t;

	typedef struct packed {
		logic [15:0] ifs_ticks;
		logic [12:0] tx_capacity;
		logic        reseed;
		logic [15:0] seed;
	} cfg_t;

endpackage

### src/cbts_cfg.sv
// ----------------------------------------------------------------------------
// cbts_cfg
// Configuration register file; a seed write raises a one-cycle reseed.
// ----------------------------------------------------------------------------
module cbts_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	output cbts_pkg::cfg_t       cfg
);
	import cbts_pkg::*;

	logic [15:0] ifs_ticks_q;
	logic [12:0] tx_capacity_q;
	logic        wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ifs_ticks_q   <= IFS_TICKS_RST;
			tx_capacity_q <= TX_CAPACITY_RST;
		end else if (wr) begin
			case (cfg_index)
				CFG_IFS_TICKS:   ifs_ticks_q   <= cfg_data;
				CFG_TX_CAPACITY: tx_capacity_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	assign cfg.ifs_ticks   = ifs_ticks_q;
	assign cfg.tx_capacity = tx_capacity_q;
	assign cfg.reseed      = wr && (cfg_index == CFG_LFSR_SEED);
	// a zero seed would lock the LFSR
	assign cfg.seed        = (cfg_data == 16'd0) ? 16'd1 : cfg_data;

endmodule

### src/cbts_core.sv
// ----------------------------------------------------------------------------
// cbts_core
// Scheduler state and its combinational update for one operation.
// ----------------------------------------------------------------------------
module cbts_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  cbts_pkg::item_t      item,
	input  cbts_pkg::cfg_t       cfg,
	output cbts_pkg::result_t    result
);
	import cbts_pkg::*;

	logic        lock_q, fault_q;
	tx_state_t   ts_q;
	logic [15:0] wait_q, retry_q, rmax_q, lfsr_q;
	logic [13:0] backoff_q;
	logic [12:0] len_q;

	logic        lock_n, fault_n;
	tx_state_t   ts_n;
	logic [15:0] wait_n, retry_n, rmax_n, lfsr_n;
	logic [13:0] backoff_n;
	logic [12:0] len_n;

	logic [15:0] lfsr_adv, mask;
	logic [4:0]  bexp;
	logic [13:0] draw;
	logic        go;
	result_t     res;

	always_comb begin
		lock_n    = lock_q;
		fault_n   = fault_q;
		ts_n      = ts_q;
		wait_n    = wait_q;
		retry_n   = retry_q;
		rmax_n    = rmax_q;
		lfsr_n    = lfsr_q;
		backoff_n = backoff_q;
		len_n     = len_q;
		go        = 1'b0;
		lfsr_adv  = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
		bexp      = 5'd0;
		mask      = 16'd0;
		draw      = 14'd0;

		res                 = '0;
		res.status          = ST_OK;
		res.posted_event    = EV_NONE;

		case (op_t'(item.operation))
			OP_TICK: begin
				if (!fault_q && !lock_q && (ts_q inside {TX_READY, TX_WAIT_ACK})) begin
					go = 1'b1;
					if (wait_q != 16'd0) begin
						wait_n = wait_q - 16'd1;
						go     = (wait_n == 16'd0);
					end
					if (go && ts_q == TX_WAIT_ACK) begin
						if (rmax_q == 16'd0 || retry_q >= rmax_q) begin
							// retries used up: drop the frame
							len_n   = 13'd0;
							retry_n = 16'd0;
							rmax_n  = 16'd0;
							ts_n    = TX_IDLE;
							go      = 1'b0;
						end else begin
							retry_n = retry_q + 16'd1;
							ts_n    = TX_READY;
						end
					end
					if (go) begin
						if (backoff_q == 14'd0) begin
							lfsr_n = lfsr_adv;
							if (retry_n >= 16'(BACKOFF_EXP_CAP))
								bexp = 5'(BACKOFF_EXP_CAP);
							else
								bexp = retry_n[4:0];
							bexp      = bexp + 5'(BACKOFF_EXP_BASE);
							mask      = 16'((17'd1 << bexp) - 17'd1);
							draw      = 14'(lfsr_adv & mask);
							backoff_n = (draw == 14'd0) ? 14'd1 : draw;
						end else begin
							backoff_n = backoff_q - 14'd1;
							if (backoff_n == 14'd0) begin
								lock_n           = 1'b1;
								res.posted_event = EV_TX_READY;
							end
						end
					end
				end
			end
			OP_LOAD: begin
				if (ts_q != TX_IDLE)
					res.status = ST_BUSY;
				else if (item.frame_length > cfg.tx_capacity)
					res.status = ST_TOO_LONG;
				else begin
					len_n   = item.frame_length;
					retry_n = 16'd0;
					rmax_n  = item.retry_limit;
					ts_n    = TX_READY;
				end
			end
			OP_CLEAR: begin
				len_n   = 13'd0;
				retry_n = 16'd0;
				rmax_n  = 16'd0;
				ts_n    = TX_IDLE;
			end
			OP_START: begin
				lock_n = 1'b1;
			end
			OP_PHY: begin
				// priority: receive, then send done, then line monitor
				if (item.recv_report inside {RR_FRAME, RR_FAULT}) begin
					if (item.recv_report == RR_FRAME)
						res.posted_event = EV_RECEIVED;
					wait_n = cfg.ifs_ticks;
					lock_n = 1'b0;
				end else if (item.send_finished) begin
					wait_n = cfg.ifs_ticks;
					lock_n = 1'b0;
					ts_n   = TX_WAIT_ACK;
				end else if (item.monitor_report == MR_FAULT && !fault_q) begin
					fault_n          = 1'b1;
					lock_n           = 1'b1;
					res.posted_event = EV_FAULT;
				end else if (item.monitor_report == MR_OK && fault_q) begin
					fault_n          = 1'b0;
					res.posted_event = EV_RECOVERED;
					wait_n           = cfg.ifs_ticks;
					lock_n           = 1'b0;
				end
			end
			OP_READY: begin
				if (!fault_q && ts_q == TX_READY) begin
					wait_n              = cfg.ifs_ticks;
					ts_n                = TX_SENDING;
					res.start_send      = 1'b1;
					res.send_from_cache = 1'b1;
					res.send_length     = len_q;
				end
			end
			OP_DIRECT: begin
				if (!fault_q && item.frame_length <= 13'(RESPONSE_MAX)) begin
					lock_n          = 1'b1;
					wait_n          = cfg.ifs_ticks;
					res.start_send  = 1'b1;
					res.send_length = item.frame_length;
				end
			end
			default: ;
		endcase

		res.awaiting_ack = (ts_n == TX_WAIT_ACK);
		res.bus_locked   = lock_n;
		res.bus_faulted  = fault_n;
		res.tx_state     = ts_n;
	end

	assign result = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q    <= 1'b0;
			fault_q   <= 1'b0;
			ts_q      <= TX_IDLE;
			wait_q    <= IFS_TICKS_RST;
			backoff_q <= 14'd0;
			retry_q   <= 16'd0;
			rmax_q    <= 16'd0;
			len_q     <= 13'd0;
			lfsr_q    <= LFSR_SEED_RST;
		end else begin
			if (fire) begin
				lock_q    <= lock_n;
				fault_q   <= fault_n;
				ts_q      <= ts_n;
				wait_q    <= wait_n;
				backoff_q <= backoff_n;
				retry_q   <= retry_n;
				rmax_q    <= rmax_n;
				len_q     <= len_n;
			end
			if (cfg.reseed)
				lfsr_q <= cfg.seed;
			else if (fire)
				lfsr_q <= lfsr_n;
		end
	end

endmodule

### src/csma_backoff_tx_scheduler_unit.sv
// ----------------------------------------------------------------------------
// csma_backoff_tx_scheduler_unit
// Carrier-sense transmit scheduler for a shared single-wire bus, with an
// inter-frame wait, LFSR-driven binary exponential backoff and bounded
// retries. Throughput is one operation per clock while the result side is
// not stalling: each operation is taken into an input register, updates the
// scheduler state and leaves its result in an output register, from which
// it can be taken once out_valid is high. The state update loop inside
// cbts_core sets the rate.
// Configuration writes are taken at any time (cfg_ready is always high) and
// are meant for idle periods; a seed write reloads the LFSR at once.
// ----------------------------------------------------------------------------
`include "csma_backoff_tx_scheduler_unit_macros.svh"

module csma_backoff_tx_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [12:0] frame_length,
	input  logic [15:0] retry_limit,
	input  logic [1:0]  recv_report,
	input  logic        send_finished,
	input  logic [1:0]  monitor_report,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [2:0]  posted_event,
	output logic        start_send,
	output logic        send_from_cache,
	output logic [12:0] send_length,
	output logic        awaiting_ack,
	output logic        bus_locked,
	output logic        bus_faulted,
	output logic [1:0]  tx_state
);
	import cbts_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2, result;
	logic    valid_s2;
	logic    out_free, fire;

	cbts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign out_free = !valid_s2 || out_ready;
	assign fire     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (out_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.operation      <= operation;
			item_s1.frame_length   <= frame_length;
			item_s1.retry_limit    <= retry_limit;
			item_s1.recv_report    <= recv_report;
			item_s1.send_finished  <= send_finished;
			item_s1.monitor_report <= monitor_report;
		end
		if (fire)
			res_s2 <= result;
	end

	cbts_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	assign out_valid       = valid_s2;
	assign status          = res_s2.status;
	assign posted_event    = res_s2.posted_event;
	assign start_send      = res_s2.start_send;
	assign send_from_cache = res_s2.send_from_cache;
	assign send_length     = res_s2.send_length;
	assign awaiting_ack    = res_s2.awaiting_ack;
	assign bus_locked      = res_s2.bus_locked;
	assign bus_faulted     = res_s2.bus_faulted;
	assign tx_state        = res_s2.tx_state;

	// no send request means no length and no source
	`CBTS_ASSERT_IMP(a_idle_send_clean, clk, arst_n, out_valid && !start_send, send_length == 13'd0 && !send_from_cache)
	// ack flag tracks the transmitter state
	`CBTS_ASSERT_IMP(a_ack_matches_state, clk, arst_n, out_valid, awaiting_ack == (tx_state == TX_WAIT_ACK))
	// a ready event always locks the bus
	`CBTS_ASSERT_IMP(a_ready_locks, clk, arst_n, out_valid && posted_event == EV_TX_READY, bus_locked && !start_send)
	// a stalled operation stays in the input register
	`CBTS_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !out_free, valid_s1 && $stable(item_s1))

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bus access scheduler. Operations are pushed
// through the input channel in bursts while the result channel stalls on its
// own pattern. Every accepted operation runs through a behavioral copy of the
// scheduler, and each result transfer is compared against the oldest
// prediction. A directed pass covers the corner cases, then biased random
// traffic walks frames through wait, backoff, send and retry under several
// register settings.
// ----------------------------------------------------------------------------
module tb_top;
	import cbts_pkg::*;

	localparam logic [2:0] OP_UNKNOWN  = 3'd7;
	localparam logic [1:0] RR_NONE     = 2'd0;
	localparam logic [1:0] RR_RESERVED = 2'd3;
	localparam logic [1:0] MR_OTHER    = 2'd2;
	localparam logic [1:0] MR_RESERVED = 2'd3;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 3000;

	// behavioral copy of the scheduler plus the queue of results still due
	class sched_scoreboard;
		logic [15:0] ifs;
		logic [12:0] cap;
		logic        bus_lock;
		logic        fault;
		tx_state_t   tx;
		logic [15:0] wait_count;
		logic [13:0] backoff;
		logic [15:0] retry_count;
		logic [15:0] retry_max;
		logic [12:0] cached_len;
		logic [15:0] lfsr;
		result_t     due_results[$];
		int          errors;

		function new();
			ifs         = IFS_TICKS_RST;
			cap         = TX_CAPACITY_RST;
			bus_lock    = 1'b0;
			fault       = 1'b0;
			tx          = TX_IDLE;
			wait_count  = IFS_TICKS_RST;
			backoff     = '0;
			retry_count = '0;
			retry_max   = '0;
			cached_len  = '0;
			lfsr        = LFSR_SEED_RST;
			errors      = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
			CFG_IFS_TICKS:   ifs = data;
			CFG_TX_CAPACITY: cap = data[12:0];
			CFG_LFSR_SEED:   lfsr = (data == 16'd0) ? 16'd1 : data;
			default: ;
			endcase
		endfunction

		function void drop_frame();
			cached_len  = '0;
			retry_count = '0;
			retry_max   = '0;
			tx          = TX_IDLE;
		endfunction

		function logic [13:0] draw_backoff();
			int unsigned exp_bits;
			logic [15:0] mask;
			logic [15:0] v;
			lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
			exp_bits = (retry_count > BACKOFF_EXP_CAP) ? BACKOFF_EXP_CAP : retry_count;
			exp_bits += BACKOFF_EXP_BASE;
			mask = (exp_bits >= 16) ? 16'hFFFF : 16'((32'd1 << exp_bits) - 1);
			v = lfsr & mask & 16'h3FFF;
			return (v == 16'd0) ? 14'd1 : v[13:0];
		endfunction

		function result_t advance_scheduler(item_t it);
			result_t r;
			logic    expired;
			r = '0;
			case (it.operation)
			OP_TICK: begin
				if (!fault && !bus_lock && (tx == TX_READY || tx == TX_WAIT_ACK)) begin
					expired = 1'b1;
					if (wait_count != 16'd0) begin
						wait_count = wait_count - 16'd1;
						expired = (wait_count == 16'd0);
					end
					// idle period ran out while waiting for ack: retry or give up
					if (expired && tx == TX_WAIT_ACK) begin
						if (retry_max == 16'd0 || retry_count >= retry_max) begin
							drop_frame();
							expired = 1'b0;
						end else begin
							retry_count = retry_count + 16'd1;
							tx = TX_READY;
						end
					end
					if (expired) begin
						if (backoff == 14'd0) begin
							backoff = draw_backoff();
						end else begin
							backoff = backoff - 14'd1;
							if (backoff == 14'd0) begin
								bus_lock = 1'b1;
								r.posted_event = EV_TX_READY;
							end
						end
					end
				end
			end
			OP_LOAD: begin
				if (tx != TX_IDLE) begin
					r.status = ST_BUSY;
				end else if (it.frame_length > cap) begin
					r.status = ST_TOO_LONG;
				end else begin
					cached_len  = it.frame_length;
					retry_count = '0;
					retry_max   = it.retry_limit;
					tx          = TX_READY;
				end
			end
			OP_CLEAR: drop_frame();
			OP_START: bus_lock = 1'b1;
			OP_PHY: begin
				// receive result wins over send finished, which wins over monitor
				if (it.recv_report == RR_FRAME || it.recv_report == RR_FAULT) begin
					if (it.recv_report == RR_FRAME)
						r.posted_event = EV_RECEIVED;
					wait_count = ifs;
					bus_lock   = 1'b0;
				end else if (it.send_finished) begin
					wait_count = ifs;
					bus_lock   = 1'b0;
					tx         = TX_WAIT_ACK;
				end else if (it.monitor_report == MR_FAULT && !fault) begin
					fault          = 1'b1;
					bus_lock       = 1'b1;
					r.posted_event = EV_FAULT;
				end else if (it.monitor_report == MR_OK && fault) begin
					fault          = 1'b0;
					r.posted_event = EV_RECOVERED;
					wait_count     = ifs;
					bus_lock       = 1'b0;
				end
			end
			OP_READY: begin
				if (!fault && tx == TX_READY) begin
					wait_count        = ifs;
					tx                = TX_SENDING;
					r.start_send      = 1'b1;
					r.send_from_cache = 1'b1;
					r.send_length     = cached_len;
				end
			end
			OP_DIRECT: begin
				if (!fault && it.frame_length <= RESPONSE_MAX) begin
					bus_lock      = 1'b1;
					wait_count    = ifs;
					r.start_send  = 1'b1;
					r.send_length = it.frame_length;
				end
			end
			default: ;
			endcase
			r.awaiting_ack = (tx == TX_WAIT_ACK);
			r.bus_locked   = bus_lock;
			r.bus_faulted  = fault;
			r.tx_state     = tx;
			return r;
		endfunction

		function void note_item(item_t it);
			due_results.push_back(advance_scheduler(it));
		endfunction

		function void check_field(string name, int unsigned want, int unsigned seen);
			if (want != seen) begin
				$error("%s: expected %0d, got %0d", name, want, seen);
				errors++;
			end
		endfunction

		function void check_result(result_t seen);
			result_t want;
			if (due_results.size() == 0) begin
				$error("result transfer with no operation outstanding");
				errors++;
				return;
			end
			want = due_results.pop_front();
			check_field("status", want.status, seen.status);
			check_field("posted_event", want.posted_event, seen.posted_event);
			check_field("start_send", want.start_send, seen.start_send);
			check_field("send_from_cache", want.send_from_cache, seen.send_from_cache);
			check_field("send_length", want.send_length, seen.send_length);
			check_field("awaiting_ack", want.awaiting_ack, seen.awaiting_ack);
			check_field("bus_locked", want.bus_locked, seen.bus_locked);
			check_field("bus_faulted", want.bus_faulted, seen.bus_faulted);
			check_field("tx_state", want.tx_state, seen.tx_state);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  operation;
	logic [12:0] frame_length;
	logic [15:0] retry_limit;
	logic [1:0]  recv_report;
	logic        send_finished;
	logic [1:0]  monitor_report;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [2:0]  posted_event;
	logic        start_send;
	logic        send_from_cache;
	logic [12:0] send_length;
	logic        awaiting_ack;
	logic        bus_locked;
	logic        bus_faulted;
	logic [1:0]  tx_state;

	sched_scoreboard sb;
	bit hold_off_req = 1'b0;
	int burst_left   = 1;
	int quiet_cycles = 0;

	csma_backoff_tx_scheduler_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.frame_length    (frame_length),
		.retry_limit     (retry_limit),
		.recv_report     (recv_report),
		.send_finished   (send_finished),
		.monitor_report  (monitor_report),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.posted_event    (posted_event),
		.start_send      (start_send),
		.send_from_cache (send_from_cache),
		.send_length     (send_length),
		.awaiting_ack    (awaiting_ack),
		.bus_locked      (bus_locked),
		.bus_faulted     (bus_faulted),
		.tx_state        (tx_state)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// transfer monitor: feeds the scoreboard on every handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_item({operation, frame_length, retry_limit, recv_report,
					send_finished, monitor_report});
			if (out_valid && out_ready)
				sb.check_result({status, posted_event, start_send, send_from_cache,
					send_length, awaiting_ack, bus_locked, bus_faulted, tx_state});
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// result side: stall pattern of its own, plus one long hold-off on request
	initial begin
		int mode;
		int span;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				mode = $urandom_range(0, 2);
				span = $urandom_range(1, 30);
				repeat (span) begin
					case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	task automatic offer(input item_t it);
		in_valid       <= 1'b1;
		operation      <= it.operation;
		frame_length   <= it.frame_length;
		retry_limit    <= it.retry_limit;
		recv_report    <= it.recv_report;
		send_finished  <= it.send_finished;
		monitor_report <= it.monitor_report;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			// no gaps while the result side is held off
			if (!hold_off_req && $urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	task automatic offer_op(input logic [2:0] op, input logic [12:0] len,
			input logic [15:0] lim, input logic [1:0] rr, input logic sf,
			input logic [1:0] mr);
		offer({op, len, lim, rr, sf, mr});
	endtask

	// stop offering and wait until every predicted result has been checked
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] ifs, input logic [12:0] cap,
			input logic [15:0] seed);
		logic [1:0]  idx[3];
		logic [15:0] val[3];
		idx = '{CFG_IFS_TICKS, CFG_TX_CAPACITY, CFG_LFSR_SEED};
		val = '{ifs, 16'(cap), seed};
		settle();
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// biased toward walking a frame through its life cycle; some pure noise
	function automatic item_t next_bus_op();
		item_t       it;
		int unsigned roll;
		it   = '0;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			it.operation      = 3'($urandom_range(0, 7));
			it.frame_length   = 13'($urandom_range(0, 4096));
			it.retry_limit    = 16'($urandom_range(0, 65535));
			it.recv_report    = 2'($urandom_range(0, 3));
			it.send_finished  = 1'($urandom_range(0, 1));
			it.monitor_report = 2'($urandom_range(0, 3));
		end else if (sb.fault) begin
			it.operation      = OP_PHY;
			it.monitor_report = (roll < 70) ? MR_OK : 2'($urandom_range(0, 3));
		end else if (sb.bus_lock) begin
			if (sb.tx == TX_READY && roll < 80) begin
				it.operation = OP_READY;
			end else if (sb.tx == TX_SENDING && roll < 85) begin
				it.operation     = OP_PHY;
				it.send_finished = 1'b1;
			end else if (roll < 90) begin
				it.operation   = OP_PHY;
				it.recv_report = roll[0] ? RR_FRAME : RR_FAULT;
			end else begin
				it.operation = OP_TICK;
			end
		end else begin
			case (sb.tx)
			TX_IDLE: begin
				if (roll < 65) begin
					it.operation    = OP_LOAD;
					it.frame_length = (roll < 20) ? 13'($urandom_range(0, 4096))
						: 13'($urandom_range(0, sb.cap));
					it.retry_limit  = (roll < 16) ? 16'($urandom_range(0, 65535))
						: 16'($urandom_range(0, 3));
				end else if (roll < 80) begin
					it.operation    = OP_DIRECT;
					it.frame_length = 13'($urandom_range(0, 30));
				end else if (roll < 88) begin
					it.operation = OP_START;
				end else begin
					it.operation = OP_TICK;
				end
			end
			TX_READY: begin
				if (roll < 90) begin
					it.operation = OP_TICK;
				end else if (roll < 94) begin
					it.operation   = OP_PHY;
					it.recv_report = RR_FRAME;
				end else if (roll < 97) begin
					it.operation = OP_START;
				end else begin
					it.operation = OP_CLEAR;
				end
			end
			TX_SENDING: begin
				if (roll < 80) begin
					it.operation     = OP_PHY;
					it.send_finished = 1'b1;
				end else begin
					it.operation = OP_TICK;
				end
			end
			default: begin
				// waiting for ack: time out into a retry, or the ack shows up
				if (roll < 76) begin
					it.operation = OP_TICK;
				end else if (roll < 88) begin
					it.operation = OP_CLEAR;
				end else if (roll < 95) begin
					it.operation   = OP_PHY;
					it.recv_report = RR_FRAME;
				end else begin
					it.operation    = OP_DIRECT;
					it.frame_length = 13'($urandom_range(0, 30));
				end
			end
			endcase
		end
		return it;
	endfunction

	task automatic run_traffic(input int count, input bit with_hold_off);
		for (int k = 0; k < count; k++) begin
			if (with_hold_off && k == count / 3)
				hold_off_req = 1'b1;
			offer(next_bus_op());
		end
	endtask

	initial begin
		sb             = new();
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		operation      = '0;
		frame_length   = '0;
		retry_limit    = '0;
		recv_report    = '0;
		send_finished  = 1'b0;
		monitor_report = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners at the reset register values
		offer_op(OP_UNKNOWN, 13'd0, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_LOAD, 13'd257, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_LOAD, 13'd0, 16'hFFFF, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_LOAD, 13'd4096, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_TICK, 13'd0, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_CLEAR, 13'd0, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_LOAD, 13'd256, 16'd1, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_START, 13'd0, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_TICK, 13'd0, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_PHY, 13'd0, 16'd0, RR_FRAME, 1'b0, MR_OK);
		offer_op(OP_PHY, 13'd0, 16'd0, RR_FAULT, 1'b1, MR_FAULT);
		offer_op(OP_PHY, 13'd0, 16'd0, RR_RESERVED, 1'b0, MR_OTHER);
		offer_op(OP_PHY, 13'd0, 16'd0, RR_NONE, 1'b0, MR_RESERVED);
		offer_op(OP_PHY, 13'd0, 16'd0, RR_NONE, 1'b0, MR_FAULT);
		offer_op(OP_READY, 13'd0, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_DIRECT, 13'd3, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_PHY, 13'd0, 16'd0, RR_NONE, 1'b0, MR_FAULT);
		offer_op(OP_PHY, 13'd0, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_DIRECT, 13'd24, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_DIRECT, 13'd25, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_PHY, 13'd0, 16'd0, RR_NONE, 1'b1, MR_FAULT);
		offer_op(OP_READY, 13'd0, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_TICK, 13'd0, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_DIRECT, 13'd4096, 16'd0, RR_NONE, 1'b0, MR_OK);
		offer_op(OP_CLEAR, 13'd0, 16'd0, RR_NONE, 1'b0, MR_OK);

		// zero idle wait and zero seed, capacity of 4096
		program_regs(16'd0, 13'd4096, 16'd0);
		run_traffic(300, 1'b1);
		program_regs(16'd1, 13'd1, 16'hFFFF);
		run_traffic(250, 1'b0);
		program_regs(16'hFFFF, 13'd13, 16'd1);
		run_traffic(40, 1'b0);
		program_regs(16'($urandom_range(2, 12)), 13'($urandom_range(1, 4096)),
			16'($urandom_range(1, 65535)));
		run_traffic(400, 1'b0);

		settle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
